// ----- rtl/tlac_pkg.sv -----
// Package for the transpose list access cost block.
// Holds field widths, payload structs and the sequencer state type.
// No dependencies.
package tlac_pkg;

	localparam int ENTRIES_DEF = 1024;
	localparam int POS_W = 10;
	localparam int COST_W = 11;
	localparam int SUM_W = 48;
	localparam int PS_W = 11;
	// Place table word: a written flag above the position.
	localparam int PLACE_W = POS_W + 1;

	typedef logic [PS_W-1:0] page_size_t;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_ACCESS = 1'b1
	} cmd_t;

	typedef struct packed {
		logic command;
		logic [POS_W-1:0] item_id;
		logic [POS_W-1:0] load_position;
	} in_item_t;

	typedef struct packed {
		logic [COST_W-1:0] access_cost;
		logic [SUM_W-1:0] total_cost;
		logic [POS_W-1:0] old_position;
		logic moved;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PRD,
		ST_PDATA,
		ST_ADDR,
		ST_ORD_PREV,
		ST_ORD_HERE,
		ST_OGOT,
		ST_OWR,
		ST_PSWAP,
		ST_PWR,
		ST_DIV,
		ST_FIN
	} state_t;

endpackage

// ----- rtl/tlac_chan_if.sv -----
// Valid/ready channel used for items, results and configuration.
// The payload type is a parameter; types come from tlac_pkg.
interface tlac_chan_if #(
	parameter type data_t = logic
);
	logic valid;
	logic ready;
	data_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/transpose_list_access_cost_top.sv -----
// Top level of the transpose-heuristic list with access cost.
// Depends on tlac_pkg, tlac_chan_if, tlac_ram and tlac_div.

// The list lives in two RAMs: an order table (position to id) and a place table
// (id to position, with a written flag). After reset the block clears the place
// table's flags, one entry a cycle, and accepts no item until then; configuration
// writes are taken at any time. Items are handled one at a time. The access time
// is set by the place read ahead of the 10-step divider for the page cost, the
// wait for the divider to finish, and the result stage; the two order reads and
// the place swap pass in turn through the single read port of each table while
// the divider runs. A finished result waits in an output register while the next
// item is taken.
module transpose_list_access_cost_top #(
	parameter int ENTRIES = tlac_pkg::ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	tlac_chan_if.sink items,
	tlac_chan_if.source results,
	tlac_chan_if.sink cfg
);
	localparam int AW = $clog2(ENTRIES);
	localparam int POS_W = tlac_pkg::POS_W;
	localparam int PLACE_W = tlac_pkg::PLACE_W;
	localparam int SUM_W = tlac_pkg::SUM_W;
	localparam int COST_W = tlac_pkg::COST_W;
	localparam logic [19:0] RECIP = 20'((2 ** 20 + ENTRIES - 1) / ENTRIES);

	// Position or id modulo ENTRIES; a reciprocal estimate with one correction.
	function automatic logic [AW-1:0] slot_of(input logic [POS_W-1:0] v);
		logic [29:0] prod;
		logic [POS_W-1:0] quo;
		logic [20:0] back;
		logic [20:0] rem;
		prod = 30'(v) * 30'(RECIP);
		quo = prod[29:20];
		back = 21'(quo) * 21'(ENTRIES);
		rem = 21'(v) - back;
		if (rem[20]) begin
			rem = rem + 21'(ENTRIES);
		end
		if (ENTRIES >= 1024) begin
			return AW'(v);
		end
		return AW'(rem);
	endfunction

	tlac_pkg::state_t state_q, state_d;

	logic [AW-1:0] clr_q;
	tlac_pkg::page_size_t ps_q;
	logic [SUM_W-1:0] sum_q;
	logic out_valid_q;
	tlac_pkg::out_item_t res_q;

	logic cmd_q;
	logic [POS_W-1:0] id_q;
	logic [POS_W-1:0] lpos_q;
	logic [AW-1:0] ids_q;
	logic [AW-1:0] lslot_q;
	logic [PLACE_W-1:0] pw_q;
	logic [POS_W-1:0] p_q;
	logic [POS_W-1:0] old_q;
	logic moved_q;
	logic [AW-1:0] here_q;
	logic [AW-1:0] prev_q;
	logic [POS_W-1:0] t_q;
	logic [POS_W-1:0] tmp_q;
	logic [AW-1:0] ts_q;

	logic pl_we, or_we;
	logic [AW-1:0] pl_waddr, pl_raddr, or_waddr, or_raddr;
	logic [PLACE_W-1:0] pl_wdata, pl_rdata;
	logic [POS_W-1:0] or_wdata, or_rdata;

	logic in_fire, fin_go, div_start, div_busy;
	logic [POS_W-1:0] div_quo;
	tlac_pkg::page_size_t div_ps;
	logic [COST_W-1:0] cost;
	logic [SUM_W:0] sum_wide;

	assign in_fire = items.valid && items.ready;
	assign items.ready = state_q == tlac_pkg::ST_IDLE;
	assign cfg.ready = 1'b1;
	assign results.valid = out_valid_q;
	assign results.data = res_q;
	assign fin_go = (state_q == tlac_pkg::ST_FIN) && (!out_valid_q || results.ready);
	assign div_start = (state_q == tlac_pkg::ST_PDATA) && (cmd_q == tlac_pkg::CMD_ACCESS);
	assign div_ps = (ps_q == '0) ? tlac_pkg::PS_W'(1) : ps_q;
	assign cost = {1'b0, div_quo} + 1'b1;
	assign sum_wide = {1'b0, sum_q} + (SUM_W + 1)'(cost);

	tlac_ram #(.WIDTH(PLACE_W), .DEPTH(ENTRIES)) u_place_ram (
		.clk(clk), .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
		.raddr(pl_raddr), .rdata(pl_rdata)
	);

	tlac_ram #(.WIDTH(POS_W), .DEPTH(ENTRIES)) u_order_ram (
		.clk(clk), .we(or_we), .waddr(or_waddr), .wdata(or_wdata),
		.raddr(or_raddr), .rdata(or_rdata)
	);

	tlac_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(pl_rdata[POS_W-1:0]),
		.divisor(div_ps), .busy(div_busy), .quotient(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlac_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pl_we = 1'b0;
		pl_waddr = ids_q;
		pl_wdata = pl_rdata;
		pl_raddr = ids_q;
		or_we = 1'b0;
		or_waddr = here_q;
		or_wdata = t_q;
		or_raddr = prev_q;
		unique case (state_q)
			tlac_pkg::ST_CLEAR: begin
				pl_we = 1'b1;
				pl_waddr = clr_q;
				pl_wdata = '0;
				if (clr_q == AW'(ENTRIES - 1)) begin
					state_d = tlac_pkg::ST_IDLE;
				end
			end
			tlac_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_d = tlac_pkg::ST_PRD;
				end
			end
			tlac_pkg::ST_PRD: begin
				state_d = tlac_pkg::ST_PDATA;
			end
			tlac_pkg::ST_PDATA: begin
				if (cmd_q == tlac_pkg::CMD_LOAD) begin
					pl_we = 1'b1;
					pl_wdata = {1'b1, lpos_q};
					or_we = 1'b1;
					or_waddr = lslot_q;
					or_wdata = id_q;
					state_d = tlac_pkg::ST_FIN;
				end else begin
					state_d = tlac_pkg::ST_ADDR;
				end
			end
			tlac_pkg::ST_ADDR: begin
				state_d = (p_q == '0) ? tlac_pkg::ST_DIV : tlac_pkg::ST_ORD_PREV;
			end
			tlac_pkg::ST_ORD_PREV: begin
				or_raddr = prev_q;
				state_d = tlac_pkg::ST_ORD_HERE;
			end
			tlac_pkg::ST_ORD_HERE: begin
				or_raddr = here_q;
				state_d = tlac_pkg::ST_OGOT;
			end
			tlac_pkg::ST_OGOT: begin
				or_we = 1'b1;
				or_waddr = here_q;
				or_wdata = t_q;
				state_d = tlac_pkg::ST_OWR;
			end
			tlac_pkg::ST_OWR: begin
				or_we = 1'b1;
				or_waddr = prev_q;
				or_wdata = tmp_q;
				pl_raddr = ts_q;
				state_d = tlac_pkg::ST_PSWAP;
			end
			tlac_pkg::ST_PSWAP: begin
				// The id takes the predecessor's place word first, so that when both
				// are the same id the second write restores its own place.
				pl_we = 1'b1;
				pl_waddr = ids_q;
				pl_wdata = pl_rdata;
				state_d = tlac_pkg::ST_PWR;
			end
			tlac_pkg::ST_PWR: begin
				pl_we = 1'b1;
				pl_waddr = ts_q;
				pl_wdata = pw_q;
				state_d = tlac_pkg::ST_DIV;
			end
			tlac_pkg::ST_DIV: begin
				if (!div_busy) begin
					state_d = tlac_pkg::ST_FIN;
				end
			end
			tlac_pkg::ST_FIN: begin
				if (fin_go) begin
					state_d = tlac_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tlac_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			ps_q <= tlac_pkg::PS_W'(1);
			sum_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == tlac_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg.valid) begin
				ps_q <= cfg.data;
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
				if (cmd_q == tlac_pkg::CMD_ACCESS) begin
					sum_q <= sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
				end
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q <= items.data.command;
			id_q <= items.data.item_id;
			lpos_q <= items.data.load_position;
			ids_q <= slot_of(items.data.item_id);
			lslot_q <= slot_of(items.data.load_position);
		end
		case (state_q)
			tlac_pkg::ST_PDATA: begin
				pw_q <= pl_rdata;
				p_q <= pl_rdata[POS_W-1:0];
				moved_q <= 1'b0;
				if (cmd_q == tlac_pkg::CMD_LOAD) begin
					old_q <= pl_rdata[PLACE_W-1] ? pl_rdata[POS_W-1:0] : '0;
				end else begin
					old_q <= pl_rdata[POS_W-1:0];
				end
			end
			tlac_pkg::ST_ADDR: begin
				here_q <= slot_of(p_q);
				prev_q <= slot_of(POS_W'(p_q - 1'b1));
				moved_q <= p_q != '0;
			end
			tlac_pkg::ST_OGOT: begin
				tmp_q <= or_rdata;
				ts_q <= slot_of(t_q);
			end
			default: begin
			end
		endcase
		if (state_q == tlac_pkg::ST_ORD_HERE) begin
			t_q <= or_rdata;
		end
		if (fin_go) begin
			res_q.old_position <= old_q;
			if (cmd_q == tlac_pkg::CMD_ACCESS) begin
				res_q.access_cost <= cost;
				res_q.total_cost <= sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
				res_q.moved <= moved_q;
			end else begin
				res_q.access_cost <= '0;
				res_q.total_cost <= sum_q;
				res_q.moved <= 1'b0;
			end
		end
	end
endmodule

// ----- rtl/tlac_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tlac_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- rtl/tlac_div.sv -----
// Restoring divider, one quotient bit per cycle, for position / page size.
// Depends on tlac_pkg for widths.
module tlac_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [tlac_pkg::POS_W-1:0] dividend,
	input logic [tlac_pkg::PS_W-1:0] divisor,
	output logic busy,
	output logic [tlac_pkg::POS_W-1:0] quotient
);
	localparam int CNT_W = $clog2(tlac_pkg::POS_W);

	logic busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [tlac_pkg::PS_W-1:0] rem_q;
	logic [tlac_pkg::PS_W-1:0] div_q;
	logic [tlac_pkg::POS_W-1:0] quo_q;
	logic [tlac_pkg::PS_W:0] trial;
	logic take;

	assign trial = {rem_q, quo_q[tlac_pkg::POS_W-1]};
	assign take = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(tlac_pkg::POS_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	// The dividend shifts out of quo_q from the top while quotient bits enter below.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? tlac_pkg::PS_W'(trial - {1'b0, div_q})
				: tlac_pkg::PS_W'(trial);
			quo_q <= {quo_q[tlac_pkg::POS_W-2:0], take};
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;
endmodule

// ----- rtl/tlac_checker.sv -----
// Port-level checks for transpose_list_access_cost_top, attached by bind.
// Depends on tlac_pkg for the result type.
module tlac_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input tlac_pkg::out_item_t out_data
);
	logic in_fire, out_fire;
	logic [tlac_pkg::SUM_W-1:0] last_total_q;

	assign in_fire = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_total_q <= '0;
		end else if (out_fire) begin
			last_total_q <= out_data.total_cost;
		end
	end

	// A waiting result holds until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Items are worked one at a time, so two transfers never come back to back.
	a_in_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_fire)
		else $error("input transfers in consecutive cycles");

	// A swap only happens on an access from a nonzero position.
	a_moved: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && out_data.moved |-> out_data.old_position != '0
			&& out_data.access_cost != '0)
		else $error("moved result from position zero or from a load");

	// The running total never decreases.
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |-> out_data.total_cost >= last_total_q)
		else $error("total cost decreased");
endmodule

bind transpose_list_access_cost_top tlac_checker u_tlac_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(items.valid),
	.in_ready(items.ready),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.out_data(results.data)
);
